// File: hw/rtl/ascii_ppm_stream_parser_assert.svh
// ---------------------------------------------------------------------------
// ascii_ppm_stream_parser_assert.svh
// assertion macros for the ppm stream parser
// ---------------------------------------------------------------------------
`ifndef ASCII_PPM_STREAM_PARSER_ASSERT_SVH
`define ASCII_PPM_STREAM_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// File: hw/rtl/ppm_pkg.sv
// ---------------------------------------------------------------------------
// ppm_pkg
// constants and types for the ascii ppm stream parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppm_pkg;

  // sizes
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int ACC_EXT_W   = SAMPLE_BITS + 4;
  localparam int KIND_W      = 3;
  localparam int POS_W       = 12;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_WIDTH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HEIGHT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MAXVAL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [SAMPLE_BITS-1:0] value;
    logic [SAMPLE_BITS-1:0] red;
    logic [SAMPLE_BITS-1:0] green;
    logic [SAMPLE_BITS-1:0] blue;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       column;
  } result_t;

endpackage

// File: hw/rtl/ascii_ppm_stream_parser.sv
// ---------------------------------------------------------------------------
// ascii_ppm_stream_parser
// byte-wide parser for plain-text p3 images: header numbers and pixels
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one character per transfer in tdata[7:0]; tlast marks the
//   end of the file and closes any open number (its tdata is ignored).
//   m_axis carries at most one result per input transfer: tuser holds the
//   kind (width, height, maxval, pixel, format error), tdata holds value,
//   red, green, blue, row and column.
//   the result of an accepted character is registered and shown on m_axis
//   in the cycle after it is accepted.
//   throughput is one character per cycle while no result waits on a stalled
//   receiver; the per-character update is a state step plus one multiply-by-ten add.
//   when the receiver stalls with a result waiting, s_axis_tready drops
//   until that result is taken; a transfer that gives no result leaves
//   m_axis_tvalid low.
//   reset clears the parser state and drops any pending result; the block
//   is then waiting for the first header line. end of stream also returns
//   the parser to that state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ascii_ppm_stream_parser_assert.svh"

module ascii_ppm_stream_parser
  import ppm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_req
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // value, red, green, blue, row, column
  output logic [2:0]  m_axis_tuser    // kind
);

  // header phase codes
  localparam logic [2:0] PH_LINE_START  = 3'd0;
  localparam logic [2:0] PH_HDR_COMMENT = 3'd1;
  localparam logic [2:0] PH_SAW_P       = 3'd2;
  localparam logic [2:0] PH_BODY        = 3'd3;
  localparam logic [2:0] PH_ERROR       = 3'd4;

  // parser state
  logic [2:0]             phase, phase_next;
  logic                   comment_skip, comment_skip_next;
  logic                   in_number, in_number_next;
  logic [SAMPLE_BITS-1:0] accumulator, accumulator_next;
  logic [1:0]             header_count, header_count_next;
  logic [1:0]             color_index, color_index_next;
  logic [DIM_W-1:0]       image_width, image_width_next;
  logic [DIM_W-1:0]       image_height, image_height_next;
  logic [DIM_W-1:0]       row_index, row_index_next;
  logic [DIM_W-1:0]       column_index, column_index_next;
  logic [SAMPLE_BITS-1:0] held_red, held_red_next;
  logic [SAMPLE_BITS-1:0] held_green, held_green_next;

  // result register
  logic    out_valid;
  result_t out_data;

  logic    res_valid;
  result_t res;
  logic    do_close;
  logic    accept;
  logic [7:0] ch;
  logic [ACC_EXT_W-1:0] acc_ext;
  logic [ACC_EXT_W-1:0] acc_sum;
  logic [DIM_W-1:0]     clamped;
  logic [DIM_W-1:0]     column_inc;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign ch            = s_axis_tdata;

  // accumulator times ten plus digit
  assign acc_ext = {{(ACC_EXT_W - SAMPLE_BITS){1'b0}}, accumulator};
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1)
                 + {{(ACC_EXT_W - 8){1'b0}}, ch - CH_ZERO};

  // header dimension clamp
  assign clamped = (accumulator > SAMPLE_BITS'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                         : accumulator[DIM_W-1:0];
  assign column_inc = column_index + 1'b1;

  // next state and result for one character
  always_comb begin
    phase_next        = phase;
    comment_skip_next = comment_skip;
    in_number_next    = in_number;
    accumulator_next  = accumulator;
    header_count_next = header_count;
    color_index_next  = color_index;
    image_width_next  = image_width;
    image_height_next = image_height;
    row_index_next    = row_index;
    column_index_next = column_index;
    held_red_next     = held_red;
    held_green_next   = held_green;
    res_valid         = 1'b0;
    res               = '0;
    do_close          = 1'b0;

    if (s_axis_tlast) begin
      if (phase == PH_BODY) begin
        do_close = in_number;
      end else if (phase != PH_ERROR) begin
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
      end
    end else begin
      unique case (phase)
        PH_LINE_START: begin
          if (ch == CH_HASH) begin
            phase_next = PH_HDR_COMMENT;
          end else if (ch == CH_P) begin
            phase_next = PH_SAW_P;
          end else begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res.kind   = KIND_ERROR;
          end
        end
        PH_HDR_COMMENT: begin
          if (ch == CH_NL) phase_next = PH_LINE_START;
        end
        PH_SAW_P: begin
          if (ch == CH_3) begin
            phase_next = PH_BODY;
          end else begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res.kind   = KIND_ERROR;
          end
        end
        PH_BODY: begin
          if (comment_skip) begin
            if (ch == CH_NL) comment_skip_next = 1'b0;
          end else if (ch == CH_HASH) begin
            do_close          = in_number;
            comment_skip_next = 1'b1;
          end else if (ch == CH_TAB || ch == CH_SPACE || ch == CH_NL) begin
            do_close = in_number;
          end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            accumulator_next = (acc_sum > ACC_EXT_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                                 : acc_sum[SAMPLE_BITS-1:0];
            in_number_next   = 1'b1;
          end
        end
        default: begin
          phase_next = PH_ERROR;
        end
      endcase
    end

    // close the open number
    if (do_close) begin
      in_number_next   = 1'b0;
      accumulator_next = '0;
      if (header_count != 2'd3) begin
        res_valid         = 1'b1;
        res.kind          = {1'b0, header_count};
        res.value         = accumulator;
        header_count_next = header_count + 1'b1;
        if (header_count == 2'd0) image_width_next = clamped;
        if (header_count == 2'd1) image_height_next = clamped;
      end else if (color_index == 2'd0) begin
        held_red_next    = accumulator;
        color_index_next = 2'd1;
      end else if (color_index == 2'd1) begin
        held_green_next  = accumulator;
        color_index_next = 2'd2;
      end else begin
        color_index_next = 2'd0;
        if (row_index < image_height) begin
          res_valid  = 1'b1;
          res.kind   = KIND_PIXEL;
          res.red    = held_red;
          res.green  = held_green;
          res.blue   = accumulator;
          res.row    = row_index[POS_W-1:0];
          res.column = column_index[POS_W-1:0];
          if (column_inc >= image_width) begin
            column_index_next = '0;
            row_index_next    = row_index + 1'b1;
          end else begin
            column_index_next = column_inc;
          end
        end
      end
    end

    // end of stream returns everything to the start
    if (s_axis_tlast) begin
      phase_next        = PH_LINE_START;
      comment_skip_next = 1'b0;
      in_number_next    = 1'b0;
      accumulator_next  = '0;
      header_count_next = '0;
      color_index_next  = '0;
      image_width_next  = '0;
      image_height_next = '0;
      row_index_next    = '0;
      column_index_next = '0;
      held_red_next     = '0;
      held_green_next   = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LINE_START;
      comment_skip <= 1'b0;
      in_number    <= 1'b0;
      accumulator  <= '0;
      header_count <= '0;
      color_index  <= '0;
      image_width  <= '0;
      image_height <= '0;
      row_index    <= '0;
      column_index <= '0;
      held_red     <= '0;
      held_green   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      comment_skip <= comment_skip_next;
      in_number    <= in_number_next;
      accumulator  <= accumulator_next;
      header_count <= header_count_next;
      color_index  <= color_index_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      row_index    <= row_index_next;
      column_index <= column_index_next;
      held_red     <= held_red_next;
      held_green   <= held_green_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_data.kind;
  assign m_axis_tdata  = {out_data.column, out_data.row, out_data.blue,
                          out_data.green, out_data.red, out_data.value};

  // checks
  `ASSERT_NEXT(a_eos_restarts, clk, rst, accept && s_axis_tlast,
    phase == PH_LINE_START && !in_number && header_count == 2'd0)
  `ASSERT_IMPLIES(a_number_in_body, clk, rst, in_number, phase == PH_BODY)
  `ASSERT_IMPLIES(a_comment_in_body, clk, rst, comment_skip, phase == PH_BODY)

endmodule

// File: tb/sv/tb_ascii_ppm_stream_parser.sv
// ---------------------------------------------------------------------------
// tb_ascii_ppm_stream_parser
// self-checking bench for the plain-text p3 image parser
// ---------------------------------------------------------------------------
// character streams go in over s_axis, one byte per transfer, with tlast as
// end of file. a scoreboard class replays every accepted character through
// its own parser model and holds the header numbers, pixels and format
// errors that must come out of m_axis, in order. stimulus is a few directed
// streams followed by random well-formed images with random content, body
// noise and broken headers. both sides idle at random; one long receiver
// hold-off and one full drain of the sender are included.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ascii_ppm_stream_parser;
  import ppm_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 9;
  localparam int TARGET_CHAR = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 20;

  // header parse phase of the model
  typedef enum logic [2:0] {
    HDR_LINE_START,
    HDR_COMMENT,
    HDR_SAW_P,
    IMG_BODY,
    FMT_ERROR
  } hdr_phase_e;

  // -------------------------------------------------------------------------
  // scoreboard: parser model plus the queue of expected results
  // -------------------------------------------------------------------------
  class ppm_scoreboard;
    result_t    expected_results[$];
    int         errors;
    hdr_phase_e phase;
    bit         in_comment;
    bit         in_number;
    int         acc;
    int         hdr_count;
    int         color_idx;
    int         img_w;
    int         img_h;
    int         row_idx;
    int         col_idx;
    logic [SAMPLE_BITS-1:0] held_r;
    logic [SAMPLE_BITS-1:0] held_g;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase      = HDR_LINE_START;
      in_comment = 1'b0;
      in_number  = 1'b0;
      acc        = 0;
      hdr_count  = 0;
      color_idx  = 0;
      img_w      = 0;
      img_h      = 0;
      row_idx    = 0;
      col_idx    = 0;
      held_r     = '0;
      held_g     = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [SAMPLE_BITS-1:0] value,
                       logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] g,
                       logic [SAMPLE_BITS-1:0] b, logic [POS_W-1:0] row,
                       logic [POS_W-1:0] column);
      result_t res;
      res.kind   = kind;
      res.value  = value;
      res.red    = r;
      res.green  = g;
      res.blue   = b;
      res.row    = row;
      res.column = column;
      expected_results.push_back(res);
    endfunction

    // a number just ended: header field or one color of a pixel
    function void close_number();
      logic [SAMPLE_BITS-1:0] v;
      v         = acc[SAMPLE_BITS-1:0];
      in_number = 1'b0;
      acc       = 0;
      if (hdr_count < 3) begin
        case (hdr_count)
          0: begin
            push(KIND_WIDTH, v, '0, '0, '0, '0, '0);
            img_w = (v > MAX_DIM) ? MAX_DIM : v;
          end
          1: begin
            push(KIND_HEIGHT, v, '0, '0, '0, '0, '0);
            img_h = (v > MAX_DIM) ? MAX_DIM : v;
          end
          default: push(KIND_MAXVAL, v, '0, '0, '0, '0, '0);
        endcase
        hdr_count++;
      end else if (color_idx == 0) begin
        held_r    = v;
        color_idx = 1;
      end else if (color_idx == 1) begin
        held_g    = v;
        color_idx = 2;
      end else begin
        color_idx = 0;
        // pixels below the last row are dropped
        if (row_idx < img_h) begin
          push(KIND_PIXEL, '0, held_r, held_g, v, row_idx[POS_W-1:0],
               col_idx[POS_W-1:0]);
          if (col_idx + 1 >= img_w) begin
            col_idx = 0;
            row_idx++;
          end else begin
            col_idx++;
          end
        end
      end
    endfunction

    // one accepted character (or end of file)
    function void note_input(logic [7:0] ch, logic eos);
      int nxt;
      if (eos) begin
        if (phase == IMG_BODY) begin
          if (in_number) close_number();
        end else if (phase != FMT_ERROR) begin
          push(KIND_ERROR, '0, '0, '0, '0, '0, '0);
        end
        clear_state();
        return;
      end
      case (phase)
        HDR_LINE_START: begin
          if (ch == CH_HASH) begin
            phase = HDR_COMMENT;
          end else if (ch == CH_P) begin
            phase = HDR_SAW_P;
          end else begin
            phase = FMT_ERROR;
            push(KIND_ERROR, '0, '0, '0, '0, '0, '0);
          end
        end
        HDR_COMMENT: begin
          if (ch == CH_NL) phase = HDR_LINE_START;
        end
        HDR_SAW_P: begin
          if (ch == CH_3) begin
            phase = IMG_BODY;
          end else begin
            phase = FMT_ERROR;
            push(KIND_ERROR, '0, '0, '0, '0, '0, '0);
          end
        end
        IMG_BODY: begin
          if (in_comment) begin
            if (ch == CH_NL) in_comment = 1'b0;
          end else if (ch == CH_HASH) begin
            if (in_number) close_number();
            in_comment = 1'b1;
          end else if (ch == CH_TAB || ch == CH_SPACE || ch == CH_NL) begin
            if (in_number) close_number();
          end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            nxt       = acc * 10 + (ch - CH_ZERO);
            acc       = (nxt > SAMPLE_MAX) ? SAMPLE_MAX : nxt;
            in_number = 1'b1;
          end
        end
        default: phase = FMT_ERROR;
      endcase
    endfunction

    function void compare_field(string name, logic [SAMPLE_BITS-1:0] exp_v,
                                logic [SAMPLE_BITS-1:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // one transfer seen on the result side
    function void check_result(logic [KIND_W-1:0] kind, logic [87:0] data);
      result_t res;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, tdata %h", kind, data);
        errors++;
        return;
      end
      res = expected_results.pop_front();
      compare_field("kind",   SAMPLE_BITS'(res.kind), SAMPLE_BITS'(kind));
      compare_field("value",  res.value,  data[15:0]);
      compare_field("red",    res.red,    data[31:16]);
      compare_field("green",  res.green,  data[47:32]);
      compare_field("blue",   res.blue,   data[63:48]);
      compare_field("row",    SAMPLE_BITS'(res.row), SAMPLE_BITS'(data[75:64]));
      compare_field("column", SAMPLE_BITS'(res.column), SAMPLE_BITS'(data[87:76]));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // signals and block under test
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // byte_req
  logic        s_axis_tlast;   // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;   // value, red, green, blue, row, column
  logic [2:0]  m_axis_tuser;   // kind

  ppm_scoreboard sb = new();

  int cycle_count;
  int chars_sent;
  int burst_left;
  bit hold_off_req;

  ascii_ppm_stream_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // receiver: stall pattern that changes mode now and then, plus hold-off
  initial begin
    int mode;
    int mode_left;
    mode          = 0;
    mode_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= mode_left[0];
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // sender tasks
  // -------------------------------------------------------------------------

  // one character transfer, in bursts with random gaps
  task automatic send_char(input logic [7:0] ch, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(ch, eos);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // decimal number, sometimes with leading zeros
  task automatic send_number(input int v);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) send_char(CH_ZERO, 1'b0);
    send_text($sformatf("%0d", v));
  endtask

  // random byte that is not a newline
  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_NL) ? 8'h41 : b;
  endfunction

  // whitespace, comment or junk between numbers
  task automatic send_separator();
    logic [7:0] junk;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_char(CH_SPACE, 1'b0);
      4: send_char(CH_TAB, 1'b0);
      5: send_char(CH_NL, 1'b0);
      6: repeat ($urandom_range(2, 3))
           send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
      7: begin
        send_char(CH_HASH, 1'b0);
        repeat ($urandom_range(0, 4)) send_char(comment_byte(), 1'b0);
        send_char(CH_NL, 1'b0);
      end
      8: begin
        // ignored character, then a real separator
        junk = $urandom_range(0, 1) ? 8'h61 : 8'($urandom_range(128, 255));
        send_char(junk, 1'b0);
        send_char(CH_SPACE, 1'b0);
      end
      default: send_text("\r\n");
    endcase
  endtask

  function automatic int pick_dim(input int small_max);
    case ($urandom_range(0, 9))
      7:       return 4095 + $urandom_range(0, 2);
      8:       return 65535;
      9:       return 123456;
      default: return $urandom_range(0, small_max);
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(65536, 9999999);
      3:       return $urandom_range(0, 255);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // well-formed image with random header, samples and separators
  task automatic send_image_stream();
    int w;
    int h;
    int pixels;
    int nsamp;
    repeat ($urandom_range(0, 2)) begin
      send_char(CH_HASH, 1'b0);
      repeat ($urandom_range(0, 5)) send_char(comment_byte(), 1'b0);
      send_char(CH_NL, 1'b0);
    end
    send_char(CH_P, 1'b0);
    send_char(CH_3, 1'b0);
    if ($urandom_range(0, 3) != 0) send_separator();
    w = pick_dim(4);
    h = pick_dim(3);
    send_number(w);
    send_separator();
    send_number(h);
    send_separator();
    send_number(pick_sample());
    send_separator();
    if (w <= 4 && h <= 3) pixels = ((w == 0) ? h : w * h) + $urandom_range(0, 2);
    else pixels = $urandom_range(0, 5);
    nsamp = 3 * pixels;
    if ($urandom_range(0, 3) == 0) nsamp += $urandom_range(1, 2);
    for (int i = 0; i < nsamp; i++) begin
      send_number(pick_sample());
      if (i < nsamp - 1 || $urandom_range(0, 1)) send_separator();
    end
    send_eos();
  endtask

  // valid magic line, then a mix of digits, whitespace and random bytes
  task automatic send_body_noise();
    send_text("P3");
    repeat ($urandom_range(10, 30)) begin
      case ($urandom_range(0, 3))
        0, 1: send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        2: case ($urandom_range(0, 3))
             0: send_char(CH_SPACE, 1'b0);
             1: send_char(CH_TAB, 1'b0);
             2: send_char(CH_NL, 1'b0);
             default: send_char(CH_HASH, 1'b0);
           endcase
        default: send_char(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    send_eos();
  endtask

  // bad or missing magic line, trailing bytes ignored
  task automatic send_broken_header();
    repeat ($urandom_range(0, 1)) begin
      send_char(CH_HASH, 1'b0);
      send_char(comment_byte(), 1'b0);
      send_char(CH_NL, 1'b0);
    end
    case ($urandom_range(0, 4))
      0: send_char(8'($urandom_range(0, 255)), 1'b0);
      1: begin
        send_char(CH_P, 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b0);
      end
      2: send_char(CH_NL, 1'b0);
      3: send_char(CH_P, 1'b0);
      default: ;
    endcase
    repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(0, 255)), 1'b0);
    send_eos();
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    bit hold_done;
    bit pause_done;
    int pick;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    chars_sent    = 0;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;

    // end of file before any header line
    send_char(8'hff, 1'b1);
    // empty magic line, then ignored bytes
    send_text("\nZ");
    send_char(8'h00, 1'b1);
    // wrong format digit
    send_text("P4");
    send_eos();
    // header comment, saturated width closed by '#', stray junk in maxval
    send_char(CH_HASH, 1'b0);
    send_char(8'h80, 1'b0);
    send_text("\nP399999#\n0\t7x8");
    send_char(8'h00, 1'b1);
    pause_sender();
    wait_for_results();

    // random streams
    while (chars_sent < TARGET_CHAR) begin
      if (!hold_done && chars_sent > 500) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && chars_sent > 900) begin
        pause_sender();
        wait_for_results();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) send_image_stream();
      else if (pick < 17) send_body_noise();
      else send_broken_header();
    end

    // drain
    pause_sender();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ppm_pkg.sv
hw/rtl/ascii_ppm_stream_parser.sv
tb/sv/tb_ascii_ppm_stream_parser.sv
